// File: rtl/vscg_pkg.sv
// Shared constants, types and helper functions for the stroke character generator.
`default_nettype none
package vscg_pkg;

	localparam int STROKE_MEM_DEPTH  = 2048;
	localparam int GLYPH_COUNT       = 128;
	localparam int MAX_GLYPH_STROKES = 64;
	localparam int COORD_WIDTH       = 16;
	localparam int QUEUE_DEPTH       = 4;

	localparam int STROKE_ADDR_W = $clog2(STROKE_MEM_DEPTH);
	localparam int GLYPH_IDX_W   = $clog2(GLYPH_COUNT);
	localparam int LEN_W         = 7;
	localparam int WIDE_W        = COORD_WIDTH + 16;
	localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] REQ_STROKE = 2'd0;
	localparam logic [1:0] REQ_GLYPH  = 2'd1;
	localparam logic [1:0] REQ_CURSOR = 2'd2;
	localparam logic [1:0] REQ_CHAR   = 2'd3;

	localparam logic [1:0] REG_STEP_X     = 2'd0;
	localparam logic [1:0] REG_STEP_Y     = 2'd1;
	localparam logic [1:0] REG_CHAR_PITCH = 2'd2;
	localparam logic [1:0] REG_DRAW_MODE  = 2'd3;

	localparam logic [1:0] AXIS_ZERO = 2'd0;
	localparam logic [1:0] AXIS_POS  = 2'd1;
	localparam logic [1:0] AXIS_NEG  = 2'd2;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic [STROKE_ADDR_W-1:0] saddr_t;
	typedef logic [GLYPH_IDX_W-1:0] glyph_idx_t;
	typedef logic [LEN_W-1:0] len_t;

	localparam wide_t COORD_MAX = wide_t'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
	localparam wide_t COORD_MIN = -COORD_MAX - wide_t'(1);

	typedef struct packed {
		logic [9:0] step_x;
		logic [9:0] step_y;
		logic [9:0] char_pitch;
		logic       draw_mode;
	} cfg_t;

	typedef struct packed {
		logic        is_store;
		logic [10:0] addr;
		logic [7:0]  data;
		len_t        len;
		coord_t      org_x;
		coord_t      org_y;
	} queue_entry_t;

	function automatic coord_t sat_coord(input wide_t v);
		coord_t r;
		if (v > COORD_MAX) begin
			r = coord_t'(COORD_MAX);
		end else if (v < COORD_MIN) begin
			r = coord_t'(COORD_MIN);
		end else begin
			r = coord_t'(v);
		end
		return r;
	endfunction

	function automatic logic [1:0] dir_x(input logic [2:0] d);
		logic [1:0] r;
		unique case (d)
			3'd1, 3'd2, 3'd3: r = AXIS_POS;
			3'd5, 3'd6, 3'd7: r = AXIS_NEG;
			default:          r = AXIS_ZERO;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] dir_y(input logic [2:0] d);
		logic [1:0] r;
		unique case (d)
			3'd0, 3'd1, 3'd7: r = AXIS_POS;
			3'd3, 3'd4, 3'd5: r = AXIS_NEG;
			default:          r = AXIS_ZERO;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/vscg_if.sv
// Channel interfaces for requests, stroke results and register writes.
`default_nettype none
interface vscg_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [7:0]         char_code;
	logic [10:0]        mem_addr;
	logic [7:0]         mem_byte;
	logic [6:0]         stroke_count;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;

	modport source (output valid, req_type, char_code, mem_addr, mem_byte, stroke_count,
		pos_x, pos_y, input ready);
	modport sink (input valid, req_type, char_code, mem_addr, mem_byte, stroke_count,
		pos_x, pos_y, output ready);
endinterface

interface vscg_stroke_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] start_x;
	logic signed [15:0] start_y;
	logic signed [15:0] end_x;
	logic signed [15:0] end_y;
	logic               pen_down;
	logic               line_mode;
	logic               last;

	modport source (output valid, start_x, start_y, end_x, end_y, pen_down, line_mode, last,
		input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, pen_down, line_mode, last,
		output ready);
endinterface

interface vscg_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [9:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/vscg_front.sv
// Front end: accepts requests, keeps the glyph directory and cursor, queues work for the back end.
`default_nettype none
module vscg_front (
	input  logic                  clk,
	input  logic                  arst_n,
	vscg_item_if.sink             req,
	input  logic [9:0]            char_pitch,
	output logic                  q_valid,
	input  logic                  q_ready,
	output vscg_pkg::queue_entry_t q_data
);
	import vscg_pkg::*;

	logic [10:0] dir_start_q [GLYPH_COUNT];
	len_t        dir_len_q [GLYPH_COUNT];
	logic        dir_vld_q [GLYPH_COUNT];

	coord_t cursor_x_q;
	coord_t cursor_y_q;

	logic        valid_s1;
	logic [1:0]  type_s1;
	logic        draw_ok_s1;
	logic [10:0] addr_s1;
	logic [7:0]  byte_s1;
	coord_t      x_s1;
	coord_t      y_s1;
	logic [10:0] start_rd_s1;
	len_t        len_rd_s1;
	logic        vld_rd_s1;

	logic       accept;
	glyph_idx_t idx;
	logic       in_dir;
	logic       draw_ok;
	logic       dir_wr;
	logic       dir_rd;
	len_t       cnt_sat;
	logic       need_push;

	assign accept  = req.valid & req.ready;
	assign idx     = GLYPH_IDX_W'(req.char_code);
	assign in_dir  = {1'b0, req.char_code} < 9'(GLYPH_COUNT);
	assign draw_ok = in_dir & ~req.char_code[7];
	assign dir_wr  = accept && (req.req_type == REQ_GLYPH) && in_dir;
	assign dir_rd  = accept && (req.req_type == REQ_CHAR) && draw_ok;
	assign cnt_sat = (req.stroke_count > len_t'(MAX_GLYPH_STROKES)) ?
		len_t'(MAX_GLYPH_STROKES) : req.stroke_count;

	assign need_push = valid_s1 && ((type_s1 == REQ_STROKE) ||
		((type_s1 == REQ_CHAR) && draw_ok_s1 && vld_rd_s1 && (len_rd_s1 != '0)));
	assign req.ready = !valid_s1 || !need_push || q_ready;

	assign q_valid        = need_push;
	assign q_data.is_store = (type_s1 == REQ_STROKE);
	assign q_data.addr     = (type_s1 == REQ_STROKE) ? addr_s1 : start_rd_s1;
	assign q_data.data     = byte_s1;
	assign q_data.len      = len_rd_s1;
	assign q_data.org_x    = x_s1;
	assign q_data.org_y    = y_s1;

	always_ff @(posedge clk) begin
		if (dir_wr) begin
			dir_start_q[idx] <= req.mem_addr;
			dir_len_q[idx]   <= cnt_sat;
		end
		if (dir_rd) begin
			start_rd_s1 <= dir_start_q[idx];
			len_rd_s1   <= dir_len_q[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GLYPH_COUNT; i++) begin
				dir_vld_q[i] <= 1'b0;
			end
			vld_rd_s1 <= 1'b0;
		end else begin
			if (dir_wr) begin
				dir_vld_q[idx] <= 1'b1;
			end
			if (dir_rd) begin
				vld_rd_s1 <= dir_vld_q[idx];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= accept;
			end
			if (accept && (req.req_type == REQ_CURSOR)) begin
				cursor_x_q <= sat_coord(wide_t'(req.pos_x));
				cursor_y_q <= sat_coord(wide_t'(req.pos_y));
			end else if (accept && (req.req_type == REQ_CHAR)) begin
				cursor_x_q <= sat_coord(wide_t'(cursor_x_q) + wide_t'(char_pitch));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_s1    <= req.req_type;
			draw_ok_s1 <= draw_ok;
			addr_s1    <= req.mem_addr;
			byte_s1    <= req.mem_byte;
			x_s1       <= cursor_x_q;
			y_s1       <= cursor_y_q;
		end
	end

endmodule
`default_nettype wire

// File: rtl/vscg_fifo.sv
// Short command queue between the front end and the stroke walker.
`default_nettype none
module vscg_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push_valid,
	output logic                   push_ready,
	input  vscg_pkg::queue_entry_t push_data,
	output logic                   pop_valid,
	input  logic                   pop_ready,
	output vscg_pkg::queue_entry_t pop_data
);
	import vscg_pkg::*;

	queue_entry_t             fifo_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [QUEUE_PTR_W:0]     count_q;
	logic                     push;
	logic                     pop;

	assign push_ready = count_q != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = fifo_q[rd_ptr_q];
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/vscg_back.sv
// Back end: stroke store and the walker that turns stroke bytes into line segments.
`default_nettype none
module vscg_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	output logic                   q_ready,
	input  vscg_pkg::queue_entry_t q_data,
	input  vscg_pkg::cfg_t         cfg_regs,
	vscg_stroke_if.source          res
);
	import vscg_pkg::*;

	logic [7:0] store_q [STROKE_MEM_DEPTH];

	len_t   seq_cnt_q;
	saddr_t seq_addr_q;
	logic   seq_first_q;
	coord_t org_x_q;
	coord_t org_y_q;

	logic       b_valid_s1;
	logic       b_first_s1;
	logic       b_last_s1;
	coord_t     b_org_x_s1;
	coord_t     b_org_y_s1;
	logic [7:0] rd_byte_s1;

	coord_t pen_x_q;
	coord_t pen_y_q;

	logic   out_valid_q;
	coord_t out_sx_q;
	coord_t out_sy_q;
	coord_t out_ex_q;
	coord_t out_ey_q;
	logic   out_pen_q;
	logic   out_mode_q;
	logic   out_last_q;

	logic        adv;
	logic        move;
	logic        issue;
	logic        pop;
	logic [13:0] mag_x;
	logic [13:0] mag_y;
	wide_t       dlt_x;
	wide_t       dlt_y;
	coord_t      sx;
	coord_t      sy;
	coord_t      ex;
	coord_t      ey;

	assign adv     = !out_valid_q || res.ready;
	assign move    = b_valid_s1 && adv;
	assign issue   = (seq_cnt_q != '0) && (!b_valid_s1 || adv);
	assign q_ready = (seq_cnt_q == '0);
	assign pop     = q_valid && q_ready;

	assign mag_x = 14'(rd_byte_s1[3:0]) * 14'(cfg_regs.step_x);
	assign mag_y = 14'(rd_byte_s1[3:0]) * 14'(cfg_regs.step_y);

	always_comb begin
		unique case (dir_x(rd_byte_s1[6:4]))
			AXIS_POS: dlt_x = wide_t'(mag_x);
			AXIS_NEG: dlt_x = -wide_t'(mag_x);
			default:  dlt_x = '0;
		endcase
		unique case (dir_y(rd_byte_s1[6:4]))
			AXIS_POS: dlt_y = wide_t'(mag_y);
			AXIS_NEG: dlt_y = -wide_t'(mag_y);
			default:  dlt_y = '0;
		endcase
	end

	assign sx = b_first_s1 ? b_org_x_s1 : pen_x_q;
	assign sy = b_first_s1 ? b_org_y_s1 : pen_y_q;
	assign ex = sat_coord(wide_t'(sx) + dlt_x);
	assign ey = sat_coord(wide_t'(sy) + dlt_y);

	always_ff @(posedge clk) begin
		if (pop && q_data.is_store) begin
			store_q[STROKE_ADDR_W'(q_data.addr)] <= q_data.data;
		end
		if (issue) begin
			rd_byte_s1 <= store_q[seq_addr_q];
			b_first_s1 <= seq_first_q;
			b_last_s1  <= (seq_cnt_q == len_t'(1));
			b_org_x_s1 <= org_x_q;
			b_org_y_s1 <= org_y_q;
		end
		if (pop && !q_data.is_store) begin
			seq_addr_q <= STROKE_ADDR_W'(q_data.addr);
			org_x_q    <= q_data.org_x;
			org_y_q    <= q_data.org_y;
		end else if (issue) begin
			seq_addr_q <= seq_addr_q + 1'b1;
		end
		if (move) begin
			pen_x_q    <= ex;
			pen_y_q    <= ey;
			out_sx_q   <= sx;
			out_sy_q   <= sy;
			out_ex_q   <= ex;
			out_ey_q   <= ey;
			out_pen_q  <= rd_byte_s1[7];
			out_mode_q <= cfg_regs.draw_mode;
			out_last_q <= b_last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_cnt_q   <= '0;
			seq_first_q <= 1'b0;
			b_valid_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && !q_data.is_store) begin
				seq_cnt_q   <= q_data.len;
				seq_first_q <= 1'b1;
			end else if (issue) begin
				seq_cnt_q   <= seq_cnt_q - 1'b1;
				seq_first_q <= 1'b0;
			end
			if (issue) begin
				b_valid_s1 <= 1'b1;
			end else if (move) begin
				b_valid_s1 <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid     = out_valid_q;
	assign res.start_x   = 16'(out_sx_q);
	assign res.start_y   = 16'(out_sy_q);
	assign res.end_x     = 16'(out_ex_q);
	assign res.end_y     = 16'(out_ey_q);
	assign res.pen_down  = out_pen_q;
	assign res.line_mode = out_mode_q;
	assign res.last      = out_last_q;

endmodule
`default_nettype wire

// File: rtl/vector_stroke_char_generator.sv
// Top level of the stroke font character generator.
// Requests arrive on req: stroke byte writes, glyph directory writes, cursor
// sets and characters. Each character yields one result on res per stroke of
// its glyph, with start, end, pen flag, draw mode and a last flag. Register
// writes on cfg are always taken and must only be issued while the block is idle.
// The front end takes one request per cycle, but holds ready low while an
// item for the queue waits for room. The walker takes a glyph from the queue
// only when it has finished the last one, and then reads one byte per stroke
// from the single read port of the stroke store.
// Codes above 127 and empty glyphs produce no results but still move the cursor.
// A four-entry queue separates the two halves, so requests keep flowing while
// the walker is busy; when res stalls, the walker holds and the queue fills
// before req drops ready.
// Reset clears the glyph directory valid bits, zeroes the cursor and loads the
// register defaults; the stroke store is not cleared and needs no startup time.
`default_nettype none
module vector_stroke_char_generator (
	input logic          clk,
	input logic          arst_n,
	vscg_item_if.sink    req,
	vscg_stroke_if.source res,
	vscg_cfg_if.sink     cfg
);
	import vscg_pkg::*;

	cfg_t         cfg_q;
	logic         q_push_valid;
	logic         q_push_ready;
	queue_entry_t q_push_data;
	logic         q_pop_valid;
	logic         q_pop_ready;
	queue_entry_t q_pop_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_x     <= 10'd10;
			cfg_q.step_y     <= 10'd20;
			cfg_q.char_pitch <= 10'd100;
			cfg_q.draw_mode  <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_STEP_X:     cfg_q.step_x     <= cfg.data;
				REG_STEP_Y:     cfg_q.step_y     <= cfg.data;
				REG_CHAR_PITCH: cfg_q.char_pitch <= cfg.data;
				REG_DRAW_MODE:  cfg_q.draw_mode  <= cfg.data[0];
				default:        cfg_q.draw_mode  <= cfg_q.draw_mode;
			endcase
		end
	end

	vscg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.char_pitch (cfg_q.char_pitch),
		.q_valid    (q_push_valid),
		.q_ready    (q_push_ready),
		.q_data     (q_push_data)
	);

	vscg_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop_data)
	);

	vscg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_pop_valid),
		.q_ready  (q_pop_ready),
		.q_data   (q_pop_data),
		.cfg_regs (cfg_q),
		.res      (res)
	);

endmodule
`default_nettype wire
